/* design/pfsm_pkg.sv */
`timescale 1ns / 1ps
// pfsm_pkg: shared types and constants for the pixel fifo pair with sprite merge
// no dependencies

package pfsm_pkg;

	localparam int unsigned COUNT_W = 4;

	localparam logic [7:0] COLOR_EMPTY = 8'hFF;
	localparam logic [7:0] COLOR_CLEAR = 8'h00;

	typedef enum logic [2:0] {
		CMD_PUSH_BG  = 3'd0,
		CMD_PUSH_SPR = 3'd1,
		CMD_POP_BG   = 3'd2,
		CMD_POP_SPR  = 3'd3,
		CMD_CLR_BG   = 3'd4,
		CMD_CLR_SPR  = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_IGNORE = 2'd0,
		MODE_FILL   = 2'd1,
		MODE_MERGE  = 2'd2
	} mode_t;

	typedef struct packed {
		logic [7:0] color;
		logic [1:0] source;
		logic [2:0] palette;
		logic       prio;
		logic [7:0] addr;
		logic [7:0] x;
	} pixel_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [2:0] pixel_index;
		logic [7:0] pixel_color;
		logic [1:0] pixel_source;
		logic [2:0] pixel_palette;
		logic       pixel_prio;
		logic [7:0] sprite_addr;
		logic [7:0] sprite_x;
	} in_item_t;

	typedef struct packed {
		logic               out_valid;
		logic               pop_error;
		logic [7:0]         out_color;
		logic [1:0]         out_source;
		logic [2:0]         out_palette;
		logic               out_prio;
		logic [7:0]         out_addr;
		logic [7:0]         out_x;
		logic [COUNT_W-1:0] bg_count;
		logic [COUNT_W-1:0] spr_count;
	} out_item_t;

endpackage

/* design/pfsm_if.sv */
`timescale 1ns / 1ps
// pfsm_in_if, pfsm_out_if: valid/ready channels for items and results
// depends on pfsm_pkg

interface pfsm_in_if;
	logic                valid;
	logic                ready;
	pfsm_pkg::in_item_t  data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface pfsm_out_if;
	logic                valid;
	logic                ready;
	pfsm_pkg::out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* design/pfsm_slot_ram.sv */
`timescale 1ns / 1ps
// pfsm_slot_ram: pixel slot memory, one write and one registered read port
// per-slot valid bits make unwritten slots read back as the reset pixel; uses pfsm_pkg

module pfsm_slot_ram #(
	parameter int unsigned DEPTH       = 8,
	parameter logic [7:0]  RESET_COLOR = 8'h00
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output pfsm_pkg::pixel_t         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  pfsm_pkg::pixel_t         wr_data
);

	pfsm_pkg::pixel_t mem [DEPTH];
	logic [DEPTH-1:0] written_q;
	pfsm_pkg::pixel_t rd_data_q;
	pfsm_pkg::pixel_t reset_pixel;

	always_comb begin
		reset_pixel       = '0;
		reset_pixel.color = RESET_COLOR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (wr_en) begin
			written_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= written_q[rd_addr] ? mem[rd_addr] : reset_pixel;
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* design/pixel_fifo_pair_with_sprite_merge.sv */
`timescale 1ns / 1ps
// pixel_fifo_pair_with_sprite_merge: background and sprite pixel ring fifos
// with row fill / merge for sprites; uses pfsm_pkg, pfsm_if, pfsm_slot_ram
//
//   channel  dir  payload              transfer when
//   op       in   pfsm_pkg::in_item_t  op.valid & op.ready
//   result   out  pfsm_pkg::out_item_t result.valid & result.ready
//
// each item has a registered slot memory read, then an update step that moves
// pointers, writes the slot back and loads the result register
// reset clears pointers, counts and row mode, and the slot valid bits, so
// slots read as zero (background) or color 0xff (sprite) until written
// a new item is taken while a result waits; the update stage holds until
// the result register is free

module pixel_fifo_pair_with_sprite_merge #(
	parameter int unsigned FIFO_DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	pfsm_in_if.sink    op,
	pfsm_out_if.source result
);

	localparam int unsigned PTR_W   = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W   = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned OUT_CNT_W = pfsm_pkg::COUNT_W;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
	localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	logic                busy_s1;
	pfsm_pkg::in_item_t  item_s1;

	logic [PTR_W-1:0]    bg_head_q, bg_tail_q, spr_head_q, spr_tail_q;
	logic [CNT_W-1:0]    bg_used_q, spr_used_q;
	logic                bg_empty_q, spr_empty_q;
	pfsm_pkg::mode_t     row_mode_q;

	logic [PTR_W-1:0]    bg_head_d, bg_tail_d, spr_head_d, spr_tail_d;
	logic [CNT_W-1:0]    bg_used_d, spr_used_d;
	logic                bg_empty_d, spr_empty_d;
	pfsm_pkg::mode_t     row_mode_d;

	logic                out_valid_q;
	pfsm_pkg::out_item_t out_data_q;
	pfsm_pkg::out_item_t res;

	logic                accept, done;
	logic [PTR_W-1:0]    spr_rd_addr;
	pfsm_pkg::pixel_t    bg_rd, spr_rd, bg_wd, spr_wd, px;
	logic                bg_we, spr_we;
	logic [PTR_W-1:0]    bg_wa, spr_wa;

	assign op.ready = !busy_s1;
	assign accept   = op.valid && !busy_s1;
	assign done     = busy_s1 && (!out_valid_q || result.ready);

	assign spr_rd_addr = (pfsm_pkg::cmd_t'(op.data.cmd) == pfsm_pkg::CMD_PUSH_SPR
		&& op.data.pixel_index != '0) ? spr_tail_q + PTR_ONE : spr_head_q;

	pfsm_slot_ram #(
		.DEPTH      (FIFO_DEPTH),
		.RESET_COLOR(pfsm_pkg::COLOR_CLEAR)
	) u_bg_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_addr(bg_head_q),
		.rd_data(bg_rd),
		.wr_en  (done && bg_we),
		.wr_addr(bg_wa),
		.wr_data(bg_wd)
	);

	pfsm_slot_ram #(
		.DEPTH      (FIFO_DEPTH),
		.RESET_COLOR(pfsm_pkg::COLOR_EMPTY)
	) u_spr_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_addr(spr_rd_addr),
		.rd_data(spr_rd),
		.wr_en  (done && spr_we),
		.wr_addr(spr_wa),
		.wr_data(spr_wd)
	);

	always_comb begin
		px.color   = item_s1.pixel_color;
		px.source  = item_s1.pixel_source;
		px.palette = item_s1.pixel_palette;
		px.prio    = item_s1.pixel_prio;
		px.addr    = item_s1.sprite_addr;
		px.x       = item_s1.sprite_x;
	end

	always_comb begin
		pfsm_pkg::mode_t  mode_v;
		logic [PTR_W-1:0] tail_v;
		logic [PTR_W-1:0] next_v;

		bg_head_d   = bg_head_q;
		bg_tail_d   = bg_tail_q;
		bg_used_d   = bg_used_q;
		bg_empty_d  = bg_empty_q;
		spr_head_d  = spr_head_q;
		spr_tail_d  = spr_tail_q;
		spr_used_d  = spr_used_q;
		spr_empty_d = spr_empty_q;
		row_mode_d  = row_mode_q;
		bg_we       = 1'b0;
		bg_wa       = bg_head_q;
		bg_wd       = bg_rd;
		spr_we      = 1'b0;
		spr_wa      = spr_head_q;
		spr_wd      = spr_rd;
		res         = '0;
		mode_v      = row_mode_q;
		tail_v      = spr_tail_q;
		next_v      = spr_tail_q + PTR_ONE;

		unique case (pfsm_pkg::cmd_t'(item_s1.cmd))
			pfsm_pkg::CMD_PUSH_BG: begin
				if (bg_empty_q) begin
					bg_head_d = '0;
				end
				bg_we        = 1'b1;
				bg_wa        = bg_tail_q + PTR_ONE;
				bg_wd        = '0;
				bg_wd.color  = item_s1.pixel_color;
				bg_wd.source = item_s1.pixel_source;
				bg_tail_d    = bg_tail_q + PTR_ONE;
				bg_empty_d   = 1'b0;
				bg_used_d    = (bg_used_q == CNT_FULL) ? bg_used_q : bg_used_q + CNT_ONE;
			end
			pfsm_pkg::CMD_PUSH_SPR: begin
				if (item_s1.pixel_index == '0) begin
					priority if (spr_empty_q
						|| (spr_head_q == '0 && item_s1.sprite_addr < spr_rd.addr)) begin
						mode_v     = pfsm_pkg::MODE_FILL;
						spr_head_d = '0;
					end else if (spr_head_q != '0 && spr_rd.x == item_s1.sprite_x) begin
						mode_v = pfsm_pkg::MODE_MERGE;
						tail_v = spr_head_q - PTR_ONE;
					end else begin
						mode_v = pfsm_pkg::MODE_IGNORE;
					end
				end
				next_v     = tail_v + PTR_ONE;
				row_mode_d = mode_v;
				spr_tail_d = tail_v;
				spr_wa     = next_v;
				spr_wd     = px;
				unique case (mode_v)
					pfsm_pkg::MODE_FILL: begin
						spr_we      = 1'b1;
						spr_tail_d  = next_v;
						spr_empty_d = 1'b0;
						spr_used_d  = (spr_used_q == CNT_FULL) ? spr_used_q
							: spr_used_q + CNT_ONE;
					end
					pfsm_pkg::MODE_MERGE: begin
						if (spr_rd.color == pfsm_pkg::COLOR_EMPTY
							|| spr_rd.color == pfsm_pkg::COLOR_CLEAR) begin
							spr_we     = 1'b1;
							spr_used_d = (spr_used_q == CNT_FULL) ? spr_used_q
								: spr_used_q + CNT_ONE;
						end
						spr_tail_d = next_v;
					end
					default: begin
					end
				endcase
			end
			pfsm_pkg::CMD_POP_BG: begin
				if (bg_empty_q || bg_used_q == '0) begin
					res.pop_error = 1'b1;
				end else begin
					res.out_valid  = 1'b1;
					res.out_color  = bg_rd.color;
					res.out_source = bg_rd.source;
					bg_we          = 1'b1;
					bg_wd.color    = pfsm_pkg::COLOR_EMPTY;
					if (bg_head_q == bg_tail_q) begin
						bg_head_d  = '0;
						bg_tail_d  = PTR_LAST;
						bg_used_d  = '0;
						bg_empty_d = 1'b1;
					end else begin
						bg_head_d = bg_head_q + PTR_ONE;
						bg_used_d = bg_used_q - CNT_ONE;
					end
				end
			end
			pfsm_pkg::CMD_POP_SPR: begin
				if (spr_empty_q || spr_used_q == '0) begin
					res.pop_error = 1'b1;
				end else begin
					res.out_valid   = 1'b1;
					res.out_color   = spr_rd.color;
					res.out_source  = spr_rd.source;
					res.out_palette = spr_rd.palette;
					res.out_prio    = spr_rd.prio;
					res.out_addr    = spr_rd.addr;
					res.out_x       = spr_rd.x;
					spr_we          = 1'b1;
					spr_wd.color    = pfsm_pkg::COLOR_EMPTY;
					if (spr_head_q == spr_tail_q) begin
						spr_head_d  = '0;
						spr_tail_d  = PTR_LAST;
						spr_used_d  = '0;
						spr_empty_d = 1'b1;
					end else begin
						spr_head_d = spr_head_q + PTR_ONE;
						spr_used_d = spr_used_q - CNT_ONE;
					end
				end
			end
			pfsm_pkg::CMD_CLR_BG: begin
				bg_head_d  = '0;
				bg_tail_d  = PTR_LAST;
				bg_used_d  = '0;
				bg_empty_d = 1'b1;
			end
			pfsm_pkg::CMD_CLR_SPR: begin
				spr_head_d  = '0;
				spr_tail_d  = PTR_LAST;
				spr_used_d  = '0;
				spr_empty_d = 1'b1;
				row_mode_d  = pfsm_pkg::MODE_IGNORE;
			end
			default: begin
			end
		endcase

		res.bg_count  = OUT_CNT_W'(bg_used_d);
		res.spr_count = OUT_CNT_W'(spr_used_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (accept) begin
			busy_s1 <= 1'b1;
		end else if (done) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= op.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_head_q   <= '0;
			bg_tail_q   <= PTR_LAST;
			bg_used_q   <= '0;
			bg_empty_q  <= 1'b1;
			spr_head_q  <= '0;
			spr_tail_q  <= PTR_LAST;
			spr_used_q  <= '0;
			spr_empty_q <= 1'b1;
			row_mode_q  <= pfsm_pkg::MODE_IGNORE;
		end else if (done) begin
			bg_head_q   <= bg_head_d;
			bg_tail_q   <= bg_tail_d;
			bg_used_q   <= bg_used_d;
			bg_empty_q  <= bg_empty_d;
			spr_head_q  <= spr_head_d;
			spr_tail_q  <= spr_tail_d;
			spr_used_q  <= spr_used_d;
			spr_empty_q <= spr_empty_d;
			row_mode_q  <= row_mode_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_data_q <= res;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

endmodule

/* test/pixel_fifo_pair_with_sprite_merge_test.sv */
`timescale 1ns / 1ps
// pixel_fifo_pair_with_sprite_merge_test: self-checking bench for the background and sprite
// pixel fifos, with directed then random pushes, pops and clears checked against a model
// depends on pfsm_pkg, pfsm_if and pixel_fifo_pair_with_sprite_merge

module pixel_fifo_pair_with_sprite_merge_test;
	import pfsm_pkg::*;

	localparam int DEPTH = 8;
	localparam int BG_SIDE = 0;
	localparam int SPR_SIDE = 1;
	localparam int RANDOM_ITEMS = 1250;
	localparam int LIMIT_CYCLES = 200000;
	localparam int SETTLE_CYCLES = 20;
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	typedef struct {
		in_item_t item;
		bit       drain;
	} pending_op_t;

	logic clk = 0;
	logic arst_n = 0;

	pfsm_in_if  op_ch();
	pfsm_out_if res_ch();

	pixel_fifo_pair_with_sprite_merge #(.FIFO_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.op(op_ch),
		.result(res_ch)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// model state
	pixel_t     fifo_slot [2][DEPTH];
	logic [2:0] fifo_head [2];
	logic [2:0] fifo_tail [2];
	logic [3:0] fifo_used [2];
	bit         fifo_empty [2];
	mode_t      row_mode;

	pending_op_t op_backlog[$];
	out_item_t   awaited_results[$];

	bit in_fire = 0;
	bit out_fire = 0;
	int in_gap = 0;
	int out_wait = 0;
	int ops_sent = 0;
	int results_checked = 0;
	int errors = 0;
	int cycle_count = 0;
	int pops_returned = 0;
	int pops_refused = 0;
	int fill_rows = 0;
	int merge_rows = 0;

	function automatic void park_fifo(int s);
		fifo_head[s] = '0;
		fifo_tail[s] = 3'd7;
		fifo_used[s] = '0;
		fifo_empty[s] = 1;
	endfunction

	function automatic void count_in(int s);
		if (fifo_used[s] < DEPTH) fifo_used[s]++;
	endfunction

	function automatic bit take_front(int s, output pixel_t px);
		logic [2:0] h;
		h = fifo_head[s];
		px = '0;
		if (fifo_empty[s] || fifo_used[s] == 0) return 0;
		px = fifo_slot[s][h];
		fifo_slot[s][h].color = COLOR_EMPTY;
		if (h == fifo_tail[s]) begin
			park_fifo(s);
		end else begin
			fifo_head[s] = h + 3'd1;
			fifo_used[s]--;
		end
		return 1;
	endfunction

	function automatic out_item_t advance_fifo_pair(in_item_t it);
		pixel_t     px, got;
		out_item_t  r;
		bit         ok, popping;
		logic [2:0] nxt;
		logic [7:0] c;
		px.color = it.pixel_color;
		px.source = it.pixel_source;
		px.palette = it.pixel_palette;
		px.prio = it.pixel_prio;
		px.addr = it.sprite_addr;
		px.x = it.sprite_x;
		got = '0;
		ok = 0;
		popping = 0;
		r = '0;
		case (it.cmd)
			CMD_PUSH_BG: begin
				if (fifo_empty[BG_SIDE]) fifo_head[BG_SIDE] = '0;
				nxt = fifo_tail[BG_SIDE] + 3'd1;
				fifo_slot[BG_SIDE][nxt].color = px.color;
				fifo_slot[BG_SIDE][nxt].source = px.source;
				fifo_tail[BG_SIDE] = nxt;
				fifo_empty[BG_SIDE] = 0;
				count_in(BG_SIDE);
			end
			CMD_PUSH_SPR: begin
				if (it.pixel_index == 0) begin
					if (fifo_empty[SPR_SIDE] || (fifo_head[SPR_SIDE] == 0 &&
							px.addr < fifo_slot[SPR_SIDE][0].addr)) begin
						row_mode = MODE_FILL;
						fifo_head[SPR_SIDE] = '0;
						fill_rows++;
					end else if (fifo_head[SPR_SIDE] != 0 &&
							fifo_slot[SPR_SIDE][fifo_head[SPR_SIDE]].x == px.x) begin
						row_mode = MODE_MERGE;
						fifo_tail[SPR_SIDE] = fifo_head[SPR_SIDE] - 3'd1;
						merge_rows++;
					end else begin
						row_mode = MODE_IGNORE;
					end
				end
				nxt = fifo_tail[SPR_SIDE] + 3'd1;
				if (row_mode == MODE_FILL) begin
					fifo_slot[SPR_SIDE][nxt] = px;
					fifo_tail[SPR_SIDE] = nxt;
					fifo_empty[SPR_SIDE] = 0;
					count_in(SPR_SIDE);
				end else if (row_mode == MODE_MERGE) begin
					c = fifo_slot[SPR_SIDE][nxt].color;
					if (c == COLOR_EMPTY || c == COLOR_CLEAR) begin
						fifo_slot[SPR_SIDE][nxt] = px;
						count_in(SPR_SIDE);
					end
					fifo_tail[SPR_SIDE] = nxt;
				end
			end
			CMD_POP_BG: begin
				popping = 1;
				ok = take_front(BG_SIDE, got);
				got.palette = '0;
				got.prio = '0;
				got.addr = '0;
				got.x = '0;
			end
			CMD_POP_SPR: begin
				popping = 1;
				ok = take_front(SPR_SIDE, got);
			end
			CMD_CLR_BG: begin
				park_fifo(BG_SIDE);
			end
			CMD_CLR_SPR: begin
				park_fifo(SPR_SIDE);
				row_mode = MODE_IGNORE;
			end
			default: begin
			end
		endcase
		if (ok) pops_returned++;
		if (popping && !ok) pops_refused++;
		r.out_valid = ok;
		r.pop_error = popping && !ok;
		if (ok) begin
			r.out_color = got.color;
			r.out_source = got.source;
			r.out_palette = got.palette;
			r.out_prio = got.prio;
			r.out_addr = got.addr;
			r.out_x = got.x;
		end
		r.bg_count = fifo_used[BG_SIDE];
		r.spr_count = fifo_used[SPR_SIDE];
		return r;
	endfunction

	function automatic logic [7:0] pick_color();
		case ($urandom_range(0, 3))
			0: return COLOR_CLEAR;
			1: return COLOR_EMPTY;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pick_x();
		case ($urandom_range(0, 4))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h5A;
			3: return 8'hA5;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic in_item_t random_pixel(logic [2:0] op_code, logic [2:0] idx);
		in_item_t it;
		it.cmd = op_code;
		it.pixel_index = idx;
		it.pixel_color = pick_color();
		it.pixel_source = 2'($urandom_range(0, 3));
		it.pixel_palette = 3'($urandom_range(0, 7));
		it.pixel_prio = 1'($urandom_range(0, 1));
		it.sprite_addr = 8'($urandom_range(0, 255));
		it.sprite_x = pick_x();
		return it;
	endfunction

	// idle stretches alternate with blocks of back-to-back transfers
	function automatic int draw_gap(int n);
		if ((n / 50) % 5 == 4) return 0;
		return $urandom_range(0, 7);
	endfunction

	task automatic enqueue(in_item_t it, bit drain);
		pending_op_t p;
		p.item = it;
		p.drain = drain;
		op_backlog.push_back(p);
	endtask

	task automatic queue_sprite_row(logic [7:0] addr, logic [7:0] x, int len, bit scramble,
			bit drain);
		in_item_t it;
		for (int i = 0; i < len; i++) begin
			it = random_pixel(CMD_PUSH_SPR, scramble ? 3'($urandom_range(0, 7)) : 3'(i));
			it.sprite_addr = addr;
			it.sprite_x = x;
			enqueue(it, drain && i == 0);
		end
	endtask

	task automatic note_field(string name, int unsigned want, int unsigned seen);
		if (want != seen) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
			errors++;
		end
	endtask

	// transfer bookkeeping, prediction and checking
	always @(posedge clk) begin
		out_item_t want, seen;
		in_fire = arst_n && op_ch.valid && op_ch.ready;
		out_fire = arst_n && res_ch.valid && res_ch.ready;
		if (!arst_n) begin
			for (int s = 0; s < 2; s++) begin
				for (int i = 0; i < DEPTH; i++) begin
					fifo_slot[s][i] = '0;
					if (s == SPR_SIDE) fifo_slot[s][i].color = COLOR_EMPTY;
				end
				park_fifo(s);
			end
			row_mode = MODE_IGNORE;
		end
		if (in_fire) awaited_results.push_back(advance_fifo_pair(op_ch.data));
		if (out_fire) begin
			seen = res_ch.data;
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, seen);
				errors++;
			end else begin
				want = awaited_results.pop_front();
				note_field("out_valid", want.out_valid, seen.out_valid);
				note_field("pop_error", want.pop_error, seen.pop_error);
				note_field("out_color", want.out_color, seen.out_color);
				note_field("out_source", want.out_source, seen.out_source);
				note_field("out_palette", want.out_palette, seen.out_palette);
				note_field("out_prio", want.out_prio, seen.out_prio);
				note_field("out_addr", want.out_addr, seen.out_addr);
				note_field("out_x", want.out_x, seen.out_x);
				note_field("bg_count", want.bg_count, seen.bg_count);
				note_field("spr_count", want.spr_count, seen.spr_count);
			end
			results_checked++;
		end
	end

	// driver and result stall, both at the falling edge
	always @(negedge clk) begin
		bit          show;
		bit          rdy;
		pending_op_t nxt;
		if (arst_n) begin
			show = 0;
			if (op_ch.valid && !in_fire) begin
				show = 1;
			end else if (in_gap != 0) begin
				in_gap--;
			end else if (op_backlog.size() != 0 &&
					(!op_backlog[0].drain || awaited_results.size() == 0)) begin
				nxt = op_backlog.pop_front();
				op_ch.data <= nxt.item;
				show = 1;
				in_gap = draw_gap(ops_sent);
				ops_sent++;
			end
			op_ch.valid <= show;
			if (out_fire) out_wait = draw_gap(results_checked);
			if (out_wait != 0) begin
				out_wait--;
				rdy = 0;
			end else begin
				rdy = 1;
			end
			res_ch.ready <= rdy;
		end else begin
			op_ch.valid <= 0;
			op_ch.data <= '0;
			res_ch.ready <= 0;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		in_item_t    it;
		int          pick, n;
		bit          drain, first;
		logic [2:0]  op_code;

		// directed: empty pops, spare codes, last-pixel pop, fill, merge, ignored row, clears
		enqueue(random_pixel(CMD_POP_BG, 3'd0), 0);
		enqueue(random_pixel(CMD_POP_SPR, 3'd7), 0);
		enqueue(random_pixel(CMD_SPARE_6, 3'd0), 0);
		enqueue(random_pixel(CMD_SPARE_7, 3'd0), 0);
		it = random_pixel(CMD_PUSH_BG, 3'd5);
		it.pixel_color = 8'hFF;
		it.pixel_source = 2'd3;
		enqueue(it, 0);
		it = random_pixel(CMD_PUSH_BG, 3'd2);
		it.pixel_color = 8'h00;
		it.pixel_source = 2'd0;
		enqueue(it, 0);
		enqueue(random_pixel(CMD_POP_BG, 3'd0), 0);
		enqueue(random_pixel(CMD_POP_BG, 3'd0), 0);
		for (int i = 0; i < DEPTH; i++) begin
			it = random_pixel(CMD_PUSH_SPR, 3'(i));
			it.pixel_color = (i == 1) ? COLOR_CLEAR : (i == 2) ? COLOR_EMPTY : 8'(8'h40 + i);
			it.pixel_palette = 3'(i);
			it.pixel_prio = 1'(i);
			it.pixel_source = 2'(i);
			it.sprite_addr = (i == 7) ? 8'hFF : 8'h80;
			it.sprite_x = 8'h10;
			enqueue(it, 0);
		end
		enqueue(random_pixel(CMD_POP_SPR, 3'd0), 0);
		enqueue(random_pixel(CMD_POP_SPR, 3'd0), 0);
		for (int i = 0; i < 2; i++) begin
			it = random_pixel(CMD_PUSH_SPR, 3'(i));
			it.pixel_color = 8'h22;
			it.sprite_addr = 8'h00;
			it.sprite_x = 8'h10;
			enqueue(it, 0);
		end
		it = random_pixel(CMD_PUSH_SPR, 3'd0);
		it.sprite_addr = 8'hFF;
		it.sprite_x = 8'h11;
		enqueue(it, 0);
		enqueue(random_pixel(CMD_PUSH_SPR, 3'd3), 0);
		enqueue(random_pixel(CMD_POP_SPR, 3'd0), 0);
		enqueue(random_pixel(CMD_CLR_BG, 3'd0), 0);
		enqueue(random_pixel(CMD_CLR_SPR, 3'd0), 0);

		// random: mostly whole rows, background push bursts and pop bursts, some broken rows, clears and noise
		n = op_backlog.size() + RANDOM_ITEMS;
		first = 1;
		while (op_backlog.size() < n) begin
			pick = $urandom_range(0, 99);
			drain = first || $urandom_range(0, 39) == 0;
			first = 0;
			if (pick < 30) begin
				queue_sprite_row(8'($urandom_range(0, 255)), pick_x(),
					($urandom_range(0, 9) == 0) ? $urandom_range(1, 7) : DEPTH,
					$urandom_range(0, 9) == 0, drain);
			end else if (pick < 50) begin
				for (int i = $urandom_range(1, 10); i > 0; i--) begin
					enqueue(random_pixel(CMD_PUSH_BG, 3'($urandom_range(0, 7))), drain);
					drain = 0;
				end
			end else if (pick < 80) begin
				op_code = $urandom_range(0, 1) ? CMD_POP_SPR : CMD_POP_BG;
				for (int i = $urandom_range(1, 6); i > 0; i--) begin
					enqueue(random_pixel(op_code, 3'($urandom_range(0, 7))), drain);
					drain = 0;
				end
			end else if (pick < 86) begin
				op_code = $urandom_range(0, 1) ? CMD_CLR_SPR : CMD_CLR_BG;
				enqueue(random_pixel(op_code, 3'($urandom_range(0, 7))), drain);
			end else begin
				for (int i = $urandom_range(1, 3); i > 0; i--) begin
					enqueue(random_pixel(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7))),
						drain);
					drain = 0;
				end
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		while (op_backlog.size() != 0 || op_ch.valid) @(negedge clk);
		while (awaited_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("run: %0d items sent, %0d results checked in %0d cycles",
			ops_sent, results_checked, cycle_count);
		$display("run: %0d pixels popped, %0d empty pops, %0d fill rows, %0d merge rows",
			pops_returned, pops_refused, fill_rows, merge_rows);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
